/* rtl/core/rbtd_pkg.sv */
// ----------------------------------------------------------------------------
// rbtd_pkg
// Types, constants and helper functions shared by the rtc time decode pipeline.
// ----------------------------------------------------------------------------
package rbtd_pkg;

    localparam logic [11:0] YEAR_BASE_LO = 12'd2000;
    localparam logic [11:0] YEAR_BASE_HI = 12'd2100;
    localparam logic [11:0] YEAR_2200    = 12'd2200;
    localparam logic [4:0]  Q100_BASE    = 5'd19;
    localparam logic [2:0]  Q400_BASE    = 3'd4;
    localparam logic [4:0]  MONTH_MAX    = 5'd12;
    localparam logic [4:0]  MONTH_MAR    = 5'd3;
    localparam logic [4:0]  HOUR_HALF    = 5'd12;
    localparam logic [4:0]  HOUR_FULL    = 5'd24;
    localparam logic [3:0]  WEEK_DAYS    = 4'd7;

    // input beat
    typedef struct packed {
        logic       transfer_ok;
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] date_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
    } in_t;

    // result beat
    typedef struct packed {
        logic        valid_res;
        logic [6:0]  second;
        logic [6:0]  minute;
        logic [5:0]  hour;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        logic        month_bad;
    } out_t;

    // after field decode
    typedef struct packed {
        logic        ok;
        logic [6:0]  second;
        logic [6:0]  minute;
        logic [5:0]  hour;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [11:0] year;
        logic        month_bad;
    } dec_t;

    // after weekday sum
    typedef struct packed {
        dec_t        dec;
        logic [11:0] wd_sum;
    } sum_t;

    // two bcd digits to binary, digits above nine decoded arithmetically
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return 8'((tens << 3) + (tens << 1) + {4'd0, b[3:0]});
    endfunction

    // sakamoto month offsets, zero for months outside the calendar
    function automatic logic [2:0] month_offset(input logic [4:0] m);
        logic [2:0] r;
        unique case (m)
            5'd1:    r = 3'd0;
            5'd2:    r = 3'd3;
            5'd3:    r = 3'd2;
            5'd4:    r = 3'd5;
            5'd5:    r = 3'd0;
            5'd6:    r = 3'd3;
            5'd7:    r = 3'd5;
            5'd8:    r = 3'd1;
            5'd9:    r = 3'd4;
            5'd10:   r = 3'd6;
            5'd11:   r = 3'd2;
            5'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/rbtd_decode_stage.sv */
// ----------------------------------------------------------------------------
// rbtd_decode_stage
// First pipeline stage: masks and bcd-decodes every register byte, folds the
// hours byte into 24-hour form and adds the century base to the year.
// ----------------------------------------------------------------------------
module rbtd_decode_stage
    import rbtd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output dec_t out_data
);

    logic valid_reg, valid_next;
    dec_t data_reg, data_next;
    logic [7:0] h12_raw, h24_raw, yy;
    logic [4:0] h12_mod;
    logic [5:0] hour_sel;
    logic [4:0] mon;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        h12_raw = bcd_decode({3'd0, in_data.hours_reg[4:0]});
        h24_raw = bcd_decode({2'd0, in_data.hours_reg[5:0]});
        // 12-hour value is at most 25, so two conditional subtracts cover mod 12
        if (h12_raw[4:0] >= HOUR_FULL) begin
            h12_mod = h12_raw[4:0] - HOUR_FULL;
        end else if (h12_raw[4:0] >= HOUR_HALF) begin
            h12_mod = h12_raw[4:0] - HOUR_HALF;
        end else begin
            h12_mod = h12_raw[4:0];
        end
        if (in_data.hours_reg[6]) begin
            hour_sel = {1'b0, h12_mod} + (in_data.hours_reg[5] ? {1'b0, HOUR_HALF} : 6'd0);
        end else begin
            hour_sel = h24_raw[5:0];
        end
        mon = 5'(bcd_decode({3'd0, in_data.month_reg[4:0]}));
        yy  = bcd_decode(in_data.year_reg);

        data_next.ok        = in_data.transfer_ok;
        data_next.second    = 7'(bcd_decode({1'b0, in_data.seconds_reg[6:0]}));
        data_next.minute    = 7'(bcd_decode({1'b0, in_data.minutes_reg[6:0]}));
        data_next.hour      = hour_sel;
        data_next.day       = 6'(bcd_decode({2'd0, in_data.date_reg[5:0]}));
        data_next.month     = mon;
        data_next.year      = {4'd0, yy} + (in_data.month_reg[7] ? YEAR_BASE_HI : YEAR_BASE_LO);
        data_next.month_bad = (mon == 5'd0) || (mon > MONTH_MAX);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rbtd_sum_stage.sv */
// ----------------------------------------------------------------------------
// rbtd_sum_stage
// Second pipeline stage: forms the sakamoto weekday sum before reduction
// mod 7. Century terms come from compares, the year span being narrow.
// ----------------------------------------------------------------------------
module rbtd_sum_stage
    import rbtd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dec_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sum_t out_data
);

    logic valid_reg, valid_next;
    sum_t data_reg, data_next;
    logic        early;
    logic [11:0] y_adj;
    logic [4:0]  q100;
    logic [2:0]  q400;
    logic [12:0] acc;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // january and february count in the previous year
        early = in_data.month < MONTH_MAR;
        y_adj = in_data.year - {11'd0, early};
        // y_adj spans 1999..2265 here
        q100 = Q100_BASE + {4'd0, y_adj >= YEAR_BASE_LO} + {4'd0, y_adj >= YEAR_BASE_HI}
             + {4'd0, y_adj >= YEAR_2200};
        q400 = Q400_BASE + {2'd0, y_adj >= YEAR_BASE_LO};
        acc  = {1'b0, y_adj} + {3'd0, y_adj[11:2]} + {10'd0, q400}
             + {10'd0, month_offset(in_data.month)} + {7'd0, in_data.day}
             - {8'd0, q100};
        data_next.dec    = in_data;
        data_next.wd_sum = acc[11:0];
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rbtd_out_stage.sv */
// ----------------------------------------------------------------------------
// rbtd_out_stage
// Last pipeline stage: reduces the weekday sum mod 7 by octal digit folding
// and builds the result beat, zeroed for a failed transfer.
// ----------------------------------------------------------------------------
module rbtd_out_stage
    import rbtd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sum_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic valid_reg, valid_next;
    out_t data_reg, data_next;
    logic [4:0] fold1;
    logic [3:0] fold2;
    logic [3:0] wd;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // 8 == 1 mod 7, so octal digits sum to the same residue
        fold1 = {2'd0, in_data.wd_sum[2:0]} + {2'd0, in_data.wd_sum[5:3]}
              + {2'd0, in_data.wd_sum[8:6]} + {2'd0, in_data.wd_sum[11:9]};
        fold2 = {2'd0, fold1[4:3]} + {1'b0, fold1[2:0]};
        wd    = (fold2 >= WEEK_DAYS) ? fold2 - WEEK_DAYS : fold2;

        if (in_data.dec.ok) begin
            data_next.valid_res = 1'b1;
            data_next.second    = in_data.dec.second;
            data_next.minute    = in_data.dec.minute;
            data_next.hour      = in_data.dec.hour;
            data_next.day       = in_data.dec.day;
            data_next.month     = in_data.dec.month;
            data_next.year      = in_data.dec.year;
            data_next.weekday   = in_data.dec.month_bad ? 3'd0 : wd[2:0];
            data_next.month_bad = in_data.dec.month_bad;
        end else begin
            data_next = '0;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rtc_bcd_time_decode.sv */
// ----------------------------------------------------------------------------
// rtc_bcd_time_decode
// Decodes one rtc register snapshot into calendar time with computed weekday.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_data (in_t)  register snapshot
//   m_       out  m_valid/m_ready    m_data (out_t) decoded time
//
// Three register stages: decode, weekday sum, mod-7 fold and output.
// One beat is accepted every cycle when m_ready is high.
// Each stage holds its beat while the next one is full, so a stall backs up
// stage by stage and nothing is dropped or repeated.
// aresetn (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module rtc_bcd_time_decode
    import rbtd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic dec_valid, dec_ready;
    dec_t dec_data;
    logic sum_valid, sum_ready;
    sum_t sum_data;

    rbtd_decode_stage u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    rbtd_sum_stage u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    rbtd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_bad_month_weekday: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.month_bad |-> m_data.weekday == 3'd0)
        else $error("weekday not zero for bad month");

    a_failed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.year == 12'd0 && !m_data.month_bad)
        else $error("failed transfer result not cleared");

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |-> m_data.year >= YEAR_BASE_LO)
        else $error("decoded year below century base");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.weekday != 3'd7)
        else $error("weekday out of range");

    a_hold_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready && !m_valid |-> s_ready)
        else $error("input stalled with empty output and sink ready");

endmodule
